@@ sv/wss_pkg.sv @@
`default_nettype none
package wss_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int WEIGHT_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SUM_W       = WEIGHT_BITS + IDX_W;
  localparam int WIN_BITS    = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_SELECTED = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_RAN_OFF  = 2'd2;

  typedef struct packed {
    logic [7:0]  antigen_id;
    logic [15:0] substrain_id;
    logic [31:0] weight;
    logic        entry_present;
    logic [15:0] random_fraction;
    logic        last_entry;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  chosen_antigen;
    logic [15:0] chosen_substrain;
    logic [1:0]  select_status;
    logic        overflow_flag;
  } out_req_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic                   store;
    logic                   drop;
    logic                   last;
    logic [7:0]             antigen;
    logic [15:0]            sid;
    logic [WEIGHT_BITS-1:0] weight;
    logic [15:0]            frac;
  } op_t;

  typedef struct packed {
    logic [15:0]      sid;
    logic [SUM_W-1:0] prefix;
    logic             positive;
  } entry_t;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_MUL  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } back_state_t;

endpackage
`default_nettype wire

@@ sv/wss_front.sv @@
`default_nettype none
module wss_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire wss_pkg::in_req_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output wss_pkg::op_t          q_op
);

  logic [wss_pkg::CNT_W-1:0] count_r, count_nxt;
  logic accept;
  logic store;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign store    = in_data.entry_present &&
                    (count_r < wss_pkg::CNT_W'(wss_pkg::MAX_ENTRIES));

  // drop requests that neither carry an entry nor end a list
  assign q_push = accept && (in_data.entry_present || in_data.last_entry);

  always_comb begin
    q_op.store   = store;
    q_op.drop    = in_data.entry_present && !store;
    q_op.last    = in_data.last_entry;
    q_op.antigen = in_data.antigen_id;
    q_op.sid     = in_data.substrain_id;
    q_op.weight  = wss_pkg::WEIGHT_BITS'(in_data.weight[wss_pkg::WIN_BITS-1:0]);
    q_op.frac    = in_data.random_fraction;
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_data.last_entry) begin
        count_nxt = '0;
      end else if (store) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/wss_queue.sv @@
`default_nettype none
module wss_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire wss_pkg::op_t  push_op,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output wss_pkg::op_t       head_op
);

  wss_pkg::op_t slot_r [wss_pkg::QUEUE_DEPTH];
  logic [wss_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [wss_pkg::QPTR_W:0]   fill_r, fill_nxt;

  assign full       = (fill_r == (wss_pkg::QPTR_W+1)'(wss_pkg::QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_op    = slot_r[rp_r];

  always_comb begin
    wp_nxt   = push ? wp_r + 1'b1 : wp_r;
    rp_nxt   = pop ? rp_r + 1'b1 : rp_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/wss_back.sv @@
`default_nettype none
module wss_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          op_valid,
  input  wire wss_pkg::op_t  op,
  output logic               op_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output wss_pkg::out_req_t  out_data
);

  localparam int PROD_W = wss_pkg::SUM_W + 16;

  wss_pkg::entry_t mem [wss_pkg::MAX_ENTRIES];
  wss_pkg::entry_t rd_data_r;
  wss_pkg::entry_t wr_data;
  logic            mem_we;

  wss_pkg::back_state_t st_r, st_nxt;
  logic [wss_pkg::SUM_W-1:0] total_r, total_nxt, target_r, target_nxt;
  logic [wss_pkg::CNT_W-1:0] cnt_r, cnt_nxt, ra_r, ra_nxt;
  logic                      drop_r, drop_nxt, dv_r, dv_nxt;
  logic [7:0]                antigen_r, antigen_nxt;
  logic [15:0]               frac_r, frac_nxt;
  logic [15:0]               chosen_r, chosen_nxt, res_sub_r, res_sub_nxt;
  logic [1:0]                res_st_r, res_st_nxt;
  logic                      out_valid_r, out_valid_nxt;
  wss_pkg::out_req_t         out_data_r, out_data_nxt;
  logic [wss_pkg::SUM_W-1:0] sum_in;
  logic [PROD_W-1:0]         prod;
  logic                      out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign op_pop    = (st_r == wss_pkg::S_LOAD) && op_valid;

  assign sum_in = total_r + wss_pkg::SUM_W'(op.weight);
  assign prod   = PROD_W'(total_r) * PROD_W'(frac_r);

  always_comb begin
    wr_data.sid      = op.sid;
    wr_data.prefix   = sum_in;
    wr_data.positive = (op.weight != '0);
    mem_we           = op_pop && op.store;
  end

  always_comb begin
    st_nxt        = st_r;
    total_nxt     = total_r;
    target_nxt    = target_r;
    cnt_nxt       = cnt_r;
    ra_nxt        = ra_r;
    drop_nxt      = drop_r;
    dv_nxt        = dv_r;
    antigen_nxt   = antigen_r;
    frac_nxt      = frac_r;
    chosen_nxt    = chosen_r;
    res_sub_nxt   = res_sub_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      wss_pkg::S_LOAD: begin
        if (op_pop) begin
          if (op.store) begin
            total_nxt = sum_in;
            cnt_nxt   = cnt_r + 1'b1;
          end
          drop_nxt = drop_r | op.drop;
          if (op.last) begin
            antigen_nxt = op.antigen;
            frac_nxt    = op.frac;
            st_nxt      = wss_pkg::S_MUL;
          end
        end
      end
      wss_pkg::S_MUL: begin
        target_nxt = prod[PROD_W-1:16];
        ra_nxt     = '0;
        dv_nxt     = 1'b0;
        chosen_nxt = '0;
        if (total_r == '0) begin
          res_sub_nxt = '0;
          res_st_nxt  = wss_pkg::ST_EMPTY;
          st_nxt      = wss_pkg::S_EMIT;
        end else begin
          st_nxt = wss_pkg::S_SCAN;
        end
      end
      wss_pkg::S_SCAN: begin
        // advance the read address; data for ra_r shows up next cycle
        dv_nxt = (ra_r < cnt_r);
        if (ra_r < cnt_r) begin
          ra_nxt = ra_r + 1'b1;
        end
        if (dv_r && rd_data_r.positive) begin
          chosen_nxt = rd_data_r.sid;
          if (rd_data_r.prefix >= target_r) begin
            res_sub_nxt = rd_data_r.sid;
            res_st_nxt  = wss_pkg::ST_SELECTED;
            st_nxt      = wss_pkg::S_EMIT;
          end
        end
        if (!dv_r && (ra_r == cnt_r)) begin
          res_sub_nxt = chosen_r;
          res_st_nxt  = wss_pkg::ST_RAN_OFF;
          st_nxt      = wss_pkg::S_EMIT;
        end
      end
      wss_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.chosen_antigen   = antigen_r;
          out_data_nxt.chosen_substrain = res_sub_r;
          out_data_nxt.select_status    = res_st_r;
          out_data_nxt.overflow_flag    = drop_r;
          total_nxt                     = '0;
          cnt_nxt                       = '0;
          drop_nxt                      = 1'b0;
          st_nxt                        = wss_pkg::S_LOAD;
        end
      end
      default: begin
        st_nxt = wss_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[wss_pkg::IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[ra_r[wss_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= wss_pkg::S_LOAD;
      total_r     <= '0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      dv_r        <= 1'b0;
      ra_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      dv_r        <= dv_nxt;
      ra_r        <= ra_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    antigen_r  <= antigen_nxt;
    frac_r     <= frac_nxt;
    chosen_r   <= chosen_nxt;
    res_sub_r  <= res_sub_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

@@ sv/weighted_substrain_select_top.sv @@
// Entry requests: one per cycle while the queue has room (4 deep).
// Final request of a list: passes the queue, then a multiply step, then a scan over the
// N stored entries through the single read port of the entry memory, then an emit step.
// Per list, the back takes one queued request at a time, then multiplies, scans and
// emits; the front keeps accepting into the queue while the back scans.
// Active-low sync reset clears only state, counts, totals, flags, pointers, out_valid.
`default_nettype none
module weighted_substrain_select_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wss_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wss_pkg::out_req_t      out_data
);

  // Front to queue
  logic         q_push;
  logic         q_full;
  wss_pkg::op_t q_in_op;

  // Queue to back
  logic         q_valid;
  logic         q_pop;
  wss_pkg::op_t q_head_op;

  // Front: accept requests, decide store or drop against capacity
  wss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_in_op)
  );

  // Short queue: let the front keep loading while the back scans
  wss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_in_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_head_op)
  );

  // Back: build prefix sums, scale target, scan memory, hold result
  wss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op        (q_head_op),
    .op_pop    (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

  // Never pop an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // Zero-total result carries substrain zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.select_status == wss_pkg::ST_EMPTY))
      |-> (out_data.chosen_substrain == 16'd0))
    else $error("empty status with nonzero substrain");

  // Status code stays within defined values
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.select_status == wss_pkg::ST_SELECTED ||
                   out_data.select_status == wss_pkg::ST_EMPTY ||
                   out_data.select_status == wss_pkg::ST_RAN_OFF))
    else $error("illegal select status");

endmodule
`default_nettype wire

@@ tb/sv/tb_weighted_substrain_select_top.sv @@
`timescale 1ns / 100ps
module tb_weighted_substrain_select_top;

  // Idle cycles with no request or result taken before the run is declared hung.
  // The limit covers the slowest list (full memory plus drops) and the idle
  // stretches of both sides on top of its scan.
  localparam int STALL_LIMIT  = 4000;
  // Quiet cycles after the last result, to catch a stray extra one.
  localparam int TAIL_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 1080;
  // The last stretch of the random part runs with no idling at all.
  localparam int CALM_ITEMS   = 250;
  localparam int MAX_PRINTS   = 40;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  wss_pkg::in_req_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  wss_pkg::out_req_t out_data;

  weighted_substrain_select_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shared run state
  bit          calm = 1'b0;
  int unsigned error_count    = 0;
  int unsigned requests_sent  = 0;
  int unsigned lists_closed   = 0;
  int unsigned lists_dropped  = 0;
  int unsigned results_seen   = 0;
  int unsigned picks_selected = 0;
  int unsigned picks_empty    = 0;

  // Shadow copy of the wheel: ids, prefix sums and positive-weight flags of the
  // list being loaded, plus the running total and the dropped-entry flag.
  bit [15:0]               wheel_ids      [wss_pkg::MAX_ENTRIES];
  bit [wss_pkg::SUM_W-1:0] wheel_prefix   [wss_pkg::MAX_ENTRIES];
  bit                      wheel_positive [wss_pkg::MAX_ENTRIES];
  int unsigned             wheel_count   = 0;
  bit [wss_pkg::SUM_W-1:0] wheel_total   = '0;
  bit                      wheel_dropped = 1'b0;

  // Choices still owed by the block, oldest first
  wss_pkg::out_req_t pending_choices[$];

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Load one request into the shadow wheel; on the final request of a list,
  // spin the wheel and queue the choice the block must return.
  function automatic void predict_selection(input wss_pkg::in_req_t req);
    bit [63:0]         w;
    bit [63:0]         target;
    bit [15:0]         chosen;
    bit [1:0]          status;
    wss_pkg::out_req_t choice;
    int unsigned       i;
    w = 64'(req.weight) & ((64'd1 << wss_pkg::WEIGHT_BITS) - 64'd1);
    if (req.entry_present) begin
      if (wheel_count < wss_pkg::MAX_ENTRIES) begin
        wheel_total                 = wheel_total + wss_pkg::SUM_W'(w);
        wheel_ids[wheel_count]      = req.substrain_id;
        wheel_prefix[wheel_count]   = wheel_total;
        wheel_positive[wheel_count] = (w != 0);
        wheel_count++;
      end else begin
        wheel_dropped = 1'b1;
      end
    end
    if (!req.last_entry) return;

    chosen = '0;
    if (wheel_total == 0) begin
      status = wss_pkg::ST_EMPTY;
    end else begin
      // Exact: total < 2^38 and the fraction < 2^16, so the product fits.
      target = (64'(wheel_total) * 64'(req.random_fraction)) >> 16;
      status = wss_pkg::ST_RAN_OFF;
      for (i = 0; i < wheel_count; i++) begin
        if (wheel_positive[i]) begin
          chosen = wheel_ids[i];
          if (64'(wheel_prefix[i]) >= target) begin
            status = wss_pkg::ST_SELECTED;
            break;
          end
        end
      end
    end
    choice.chosen_antigen   = req.antigen_id;
    choice.chosen_substrain = chosen;
    choice.select_status    = status;
    choice.overflow_flag    = wheel_dropped;
    pending_choices.insert(pending_choices.size(), choice);
    lists_closed++;
    if (wheel_dropped) lists_dropped++;
    wheel_count   = 0;
    wheel_total   = '0;
    wheel_dropped = 1'b0;
  endfunction

  // Compare each accepted result with the oldest owed choice
  always @(posedge clk) begin : check_results
    wss_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_choices.size() == 0) begin
        report_mismatch("result with no request waiting", 64'(out_data), 64'd0);
      end else begin
        want = pending_choices.pop_front();
        if (out_data.chosen_antigen !== want.chosen_antigen)
          report_mismatch("chosen_antigen", 64'(out_data.chosen_antigen),
                          64'(want.chosen_antigen));
        if (out_data.chosen_substrain !== want.chosen_substrain)
          report_mismatch("chosen_substrain", 64'(out_data.chosen_substrain),
                          64'(want.chosen_substrain));
        if (out_data.select_status !== want.select_status)
          report_mismatch("select_status", 64'(out_data.select_status),
                          64'(want.select_status));
        if (out_data.overflow_flag !== want.overflow_flag)
          report_mismatch("overflow_flag", 64'(out_data.overflow_flag),
                          64'(want.overflow_flag));
        if (want.select_status == wss_pkg::ST_EMPTY) picks_empty++;
        else picks_selected++;
      end
    end
  end

  // Hold the result channel in random stall bursts
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Drop the run if neither channel moves for too long
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", idle_cycles);
        $display("FAIL weighted_substrain_select_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one request, hold it until accepted, then predict from it.
  // Valid stays high afterwards so back-to-back requests need no gap.
  task automatic send_request(input wss_pkg::in_req_t req);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predict_selection(req);
    requests_sent++;
  endtask

  function automatic wss_pkg::in_req_t make_request(input logic [7:0] antigen,
                                                    input logic [15:0] sid,
                                                    input logic [31:0] weight,
                                                    input logic present,
                                                    input logic [15:0] frac,
                                                    input logic last);
    wss_pkg::in_req_t req;
    req.antigen_id      = antigen;
    req.substrain_id    = sid;
    req.weight          = weight;
    req.entry_present   = present;
    req.random_fraction = frac;
    req.last_entry      = last;
    return req;
  endfunction

  // Pause the sender until every owed choice has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_choices.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_weight(input bit zero_only);
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (zero_only || pick == 0) return 32'd0;
    if (pick == 1) return 32'hFFFF_FFFF;
    if (pick <= 3) return 32'($urandom_range(1, 255));
    return 32'($urandom);
  endfunction

  function automatic logic [15:0] random_fraction();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Empty list and a list whose weights are all zero
  task automatic test_empty_list();
    send_request(make_request(8'h00, 16'h1234, 32'h0, 1'b0, 16'h8000, 1'b1));
    send_request(make_request(8'hFF, 16'h0001, 32'h0, 1'b1, 16'hFFFF, 1'b0));
    send_request(make_request(8'hFF, 16'hFFFF, 32'h0, 1'b1, 16'h0000, 1'b0));
    send_request(make_request(8'h5A, 16'h00AA, 32'h0, 1'b1, 16'hFFFF, 1'b1));
  endtask

  // One-entry lists at the extremes of every field
  task automatic test_single_extremes();
    send_request(make_request(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
    send_request(make_request(8'h00, 16'h0000, 32'h0000_0001, 1'b1, 16'h0000, 1'b1));
    send_request(make_request(8'hA5, 16'h5A5A, 32'h0100_0000, 1'b1, 16'hFFFF, 1'b1));
  endtask

  // Zero-weight entries are stored but must never be the pick
  task automatic test_zero_weight_skip();
    int unsigned pass_no;
    for (pass_no = 0; pass_no < 2; pass_no++) begin
      send_request(make_request(8'h11, 16'h0100, 32'h0, 1'b1, 16'h0, 1'b0));
      send_request(make_request(8'h11, 16'h0200, 32'h0300_0000, 1'b1, 16'h0, 1'b0));
      send_request(make_request(8'h11, 16'h0300, 32'h0, 1'b1, 16'h0, 1'b0));
      send_request(make_request(8'h22, 16'h0400, 32'h0000_0010, 1'b1,
                                pass_no ? 16'hFFFF : 16'h0000, 1'b1));
    end
  endtask

  // Requests without an entry mid-list and as the closing request
  task automatic test_absent_entries();
    send_request(make_request(8'h33, 16'h0A0A, 32'h0200_0000, 1'b1, 16'h0, 1'b0));
    send_request(make_request(8'h33, 16'hDEAD, 32'hFFFF_FFFF, 1'b0, 16'h0, 1'b0));
    send_request(make_request(8'h33, 16'h0B0B, 32'h0200_0000, 1'b1, 16'h0, 1'b0));
    send_request(make_request(8'h44, 16'hBEEF, 32'hFFFF_FFFF, 1'b0, 16'hC000, 1'b1));
    send_request(make_request(8'h44, 16'hBEEF, 32'h0, 1'b0, 16'h0000, 1'b1));
  endtask

  // Target exactly on a prefix sum picks that entry; one step above picks the next
  task automatic test_target_boundary();
    send_request(make_request(8'h66, 16'h0001, 32'h0400_0000, 1'b1, 16'h0, 1'b0));
    send_request(make_request(8'h66, 16'h0002, 32'h0400_0000, 1'b1, 16'h8000, 1'b1));
    send_request(make_request(8'h77, 16'h0003, 32'h0400_0000, 1'b1, 16'h0, 1'b0));
    send_request(make_request(8'h77, 16'h0004, 32'h0400_0000, 1'b1, 16'h8001, 1'b1));
  endtask

  // Fill the memory exactly, then overfill it twice, each time dropping the closer
  task automatic test_capacity_overflow();
    int unsigned lens[3] = '{wss_pkg::MAX_ENTRIES, wss_pkg::MAX_ENTRIES + 1,
                             wss_pkg::MAX_ENTRIES + 6};
    int unsigned li;
    int unsigned i;
    logic [7:0]  antigen;
    for (li = 0; li < 3; li++) begin
      antigen = 8'($urandom_range(0, 255));
      for (i = 0; i < lens[li]; i++)
        send_request(make_request(antigen, 16'($urandom_range(0, 65535)), random_weight(1'b0),
                                  1'b1, random_fraction(), i == lens[li] - 1));
    end
  endtask

  // Mostly short well-formed lists with random content, some long and some
  // overfilled, with stray empty requests mixed in.
  task automatic test_random_lists();
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    int unsigned i;
    bit          zero_list;
    logic [7:0]  antigen;
    start = requests_sent;
    while (requests_sent - start < RANDOM_ITEMS) begin
      calm = (requests_sent - start >= RANDOM_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(wss_pkg::MAX_ENTRIES - 4, wss_pkg::MAX_ENTRIES + 6);
      zero_list = ($urandom_range(0, 19) == 0);
      antigen   = 8'($urandom_range(0, 255));
      for (i = 0; i < len; i++) begin
        send_request(make_request(antigen, 16'($urandom_range(0, 65535)),
                                  random_weight(zero_list), $urandom_range(0, 15) != 0,
                                  random_fraction(), i == len - 1));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    wait_for_results();
    test_single_extremes();
    wait_for_results();
    test_zero_weight_skip();
    wait_for_results();
    test_absent_entries();
    wait_for_results();
    test_target_boundary();
    wait_for_results();
    test_capacity_overflow();
    wait_for_results();
    test_random_lists();

    // Drain, then watch a quiet stretch for anything extra
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_choices.size() != 0)
      report_mismatch("choices never returned", 64'(pending_choices.size()), 64'd0);

    $display("covered %0d requests in %0d lists, %0d of them with dropped entries",
             requests_sent, lists_closed, lists_dropped);
    $display("checked %0d results: %0d picks, %0d zero-total lists, %0d mismatches",
             results_seen, picks_selected, picks_empty, error_count);
    if (error_count == 0) begin
      $display("PASS weighted_substrain_select_top");
    end else begin
      $display("FAIL weighted_substrain_select_top");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/wss_pkg.sv
sv/wss_front.sv
sv/wss_queue.sv
sv/wss_back.sv
sv/weighted_substrain_select_top.sv
tb/sv/tb_weighted_substrain_select_top.sv
